// ===== design/swr_pkg.sv =====
// Shared types and constants for the square window rotator.
// Used by swr_matrix_mem, swr_ctrl and square_window_rotator; no dependencies.
package swr_pkg;

  localparam int MAX_SIDE_DEF = 512;
  localparam int VAL_W        = 19;
  localparam int SIZE_W       = 10;
  localparam int SIDE_W       = 11;
  localparam int COORD_W      = 10;
  localparam int RAD_W        = 8;
  localparam int REQ_W        = 2;
  localparam int PHASE_W      = 3;

  localparam logic [SIZE_W-1:0]  SIZE_RESET = 10'd512;
  localparam logic [0:0]         REG_SIZE_IN_USE = 1'b0;
  localparam logic [PHASE_W-1:0] PH_LAST_READ = 3'd3;
  localparam logic [PHASE_W-1:0] PH_FIRST_WRITE = 3'd2;
  localparam logic [PHASE_W-1:0] PH_LAST = 3'd5;

  typedef enum logic [REQ_W-1:0] {
    REQ_ROTATE = 2'd0,
    REQ_READ   = 2'd1,
    REQ_FILL   = 2'd2
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_READ,
    ST_RDATA,
    ST_ROT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  typedef struct packed {
    logic             valid;
    logic             status;
    logic [VAL_W-1:0] value;
  } result_t;

endpackage

// ===== design/swr_matrix_mem.sv =====
// Matrix cell store: one write port and one read port with registered read data.
// Depends on swr_pkg.
module swr_matrix_mem #(
  parameter int DEPTH = swr_pkg::MAX_SIDE_DEF * swr_pkg::MAX_SIDE_DEF,
  parameter int AW    = 18
) (
  input  logic                     clk,
  input  swr_pkg::mem_ctl_t        ctl,
  input  logic [AW-1:0]            waddr,
  input  logic [swr_pkg::VAL_W-1:0] wdata,
  input  logic [AW-1:0]            raddr,
  output logic [swr_pkg::VAL_W-1:0] rdata
);

  logic [swr_pkg::VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/swr_ctrl.sv =====
// Request sequencer: checks requests, sweeps fills, reads single cells and walks rotation orbits
// with read-modify-write on the matrix memory. Depends on swr_pkg.
module swr_ctrl #(
  parameter int MAX_SIDE = swr_pkg::MAX_SIDE_DEF,
  parameter int IW       = 9,
  parameter int AW       = 18
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          idle,
  input  logic [swr_pkg::REQ_W-1:0]     req_type,
  input  logic [swr_pkg::COORD_W-1:0]   row,
  input  logic [swr_pkg::COORD_W-1:0]   col,
  input  logic [swr_pkg::RAD_W-1:0]     radius,
  input  logic                          counter_clockwise,
  input  logic [swr_pkg::SIDE_W-1:0]    side,
  input  logic                          res_take,
  output swr_pkg::result_t              res,
  output swr_pkg::mem_ctl_t             mem_ctl,
  output logic [AW-1:0]                 raddr,
  output logic [AW-1:0]                 waddr,
  output logic [swr_pkg::VAL_W-1:0]     wdata,
  input  logic [swr_pkg::VAL_W-1:0]     rdata
);

  swr_pkg::state_t state, state_next;

  logic [swr_pkg::COORD_W-1:0] a, b;
  logic [swr_pkg::RAD_W-1:0]   r;
  logic                        ccw;
  logic [swr_pkg::RAD_W-1:0]   di, dj;
  logic [swr_pkg::PHASE_W-1:0] phase;
  logic [IW-1:0]               fi, fj;
  logic [swr_pkg::VAL_W-1:0]   fcount;
  logic [swr_pkg::VAL_W-1:0]   carry;
  logic [AW-1:0]               prev_addr, addr0;
  logic                        res_status;
  logic [swr_pkg::VAL_W-1:0]   res_value;

  logic [swr_pkg::SIDE_W-1:0] side_m1, row_w, col_w, rad_w;
  logic                       win_bad, cell_bad, req_bad;
  logic                       fill_last, orbit_last_dj, orbit_last_di;
  logic [1:0]                 qsel, psel_pos;
  logic [11:0]                dis, djs, x, y, ri, ci;
  logic [IW-1:0]              gen_row, gen_col;
  logic [AW-1:0]              gen_addr;
  logic                       rot_read, rot_write;

  assign side_m1 = side - 11'd1;
  assign row_w   = {1'b0, row};
  assign col_w   = {1'b0, col};
  assign rad_w   = {3'b000, radius};

  assign win_bad = (row_w <= rad_w) || ((row_w + rad_w) > side) ||
                   (col_w <= rad_w) || ((col_w + rad_w) > side);
  assign cell_bad = (row == '0) || (row_w > side) || (col == '0) || (col_w > side);

  always_comb begin
    unique case (swr_pkg::req_kind_t'(req_type))
      swr_pkg::REQ_ROTATE: req_bad = win_bad;
      swr_pkg::REQ_READ:   req_bad = cell_bad;
      swr_pkg::REQ_FILL:   req_bad = 1'b0;
      default:             req_bad = 1'b1;
    endcase
  end

  assign fill_last = ({{(swr_pkg::SIDE_W-IW){1'b0}}, fi} == side_m1) &&
                     ({{(swr_pkg::SIDE_W-IW){1'b0}}, fj} == side_m1);
  assign orbit_last_dj = (dj == r);
  assign orbit_last_di = (di == r);

  // Counter-clockwise walks the same orbit in the opposite order.
  assign qsel     = phase[1:0];
  assign psel_pos = (ccw && qsel[0]) ? (qsel ^ 2'b10) : qsel;
  assign dis      = {4'b0000, di};
  assign djs      = {4'b0000, dj};

  always_comb begin
    unique case (psel_pos)
      2'd0: begin
        x = dis;
        y = djs;
      end
      2'd1: begin
        x = djs;
        y = 12'd0 - dis;
      end
      2'd2: begin
        x = 12'd0 - dis;
        y = 12'd0 - djs;
      end
      default: begin
        x = 12'd0 - djs;
        y = dis;
      end
    endcase
  end

  always_comb begin
    ri = {2'b00, a} - 12'd1;
    ci = {2'b00, b} - 12'd1;
    if (state == swr_pkg::ST_ROT) begin
      ri = ri + x;
      ci = ci + y;
    end
  end

  assign gen_row  = (state == swr_pkg::ST_FILL) ? fi : ri[IW-1:0];
  assign gen_col  = (state == swr_pkg::ST_FILL) ? fj : ci[IW-1:0];
  assign gen_addr = AW'(gen_row) * AW'(MAX_SIDE) + AW'(gen_col);

  assign rot_read  = (state == swr_pkg::ST_ROT) && (phase <= swr_pkg::PH_LAST_READ);
  assign rot_write = (state == swr_pkg::ST_ROT) && (phase >= swr_pkg::PH_FIRST_WRITE);

  assign raddr = gen_addr;

  always_comb begin
    mem_ctl.rd_en = rot_read || (state == swr_pkg::ST_READ);
    mem_ctl.wr_en = rot_write || (state == swr_pkg::ST_FILL);
    if (state == swr_pkg::ST_FILL) begin
      waddr = gen_addr;
      wdata = fcount;
    end else begin
      waddr = (phase == swr_pkg::PH_LAST) ? addr0 : prev_addr;
      wdata = carry;
    end
  end

  assign idle       = (state == swr_pkg::ST_IDLE);
  assign res.valid  = (state == swr_pkg::ST_DONE);
  assign res.status = res_status;
  assign res.value  = res_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      swr_pkg::ST_IDLE: begin
        if (req_valid) begin
          if (req_bad) begin
            state_next = swr_pkg::ST_DONE;
          end else begin
            unique case (swr_pkg::req_kind_t'(req_type))
              swr_pkg::REQ_ROTATE:
                state_next = (radius == '0) ? swr_pkg::ST_DONE : swr_pkg::ST_ROT;
              swr_pkg::REQ_READ: state_next = swr_pkg::ST_READ;
              swr_pkg::REQ_FILL: state_next = swr_pkg::ST_FILL;
              default:           state_next = swr_pkg::ST_DONE;
            endcase
          end
        end
      end
      swr_pkg::ST_FILL: begin
        if (fill_last) begin
          state_next = swr_pkg::ST_DONE;
        end
      end
      swr_pkg::ST_READ:  state_next = swr_pkg::ST_RDATA;
      swr_pkg::ST_RDATA: state_next = swr_pkg::ST_DONE;
      swr_pkg::ST_ROT: begin
        if ((phase == swr_pkg::PH_LAST) && orbit_last_dj && orbit_last_di) begin
          state_next = swr_pkg::ST_DONE;
        end
      end
      swr_pkg::ST_DONE: begin
        if (res_take) begin
          state_next = swr_pkg::ST_IDLE;
        end
      end
      default: state_next = swr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prev_addr <= gen_addr;
    if ((state == swr_pkg::ST_IDLE) && req_valid) begin
      a          <= row;
      b          <= col;
      r          <= radius;
      ccw        <= counter_clockwise;
      di         <= 8'd1;
      dj         <= '0;
      phase      <= '0;
      fi         <= '0;
      fj         <= '0;
      fcount     <= 19'd1;
      res_value  <= '0;
      res_status <= req_bad;
    end
    if (state == swr_pkg::ST_FILL) begin
      fcount <= fcount + 19'd1;
      if ({{(swr_pkg::SIDE_W-IW){1'b0}}, fj} == side_m1) begin
        fj <= '0;
        fi <= fi + IW'(1);
      end else begin
        fj <= fj + IW'(1);
      end
    end
    if (state == swr_pkg::ST_RDATA) begin
      res_value <= rdata;
    end
    if (state == swr_pkg::ST_ROT) begin
      if (phase == '0) begin
        addr0 <= gen_addr;
      end
      if ((phase != '0) && (phase != swr_pkg::PH_LAST)) begin
        carry <= rdata;
      end
      if (phase == swr_pkg::PH_LAST) begin
        phase <= '0;
        if (orbit_last_dj) begin
          dj <= '0;
          di <= di + 8'd1;
        end else begin
          dj <= dj + 8'd1;
        end
      end else begin
        phase <= phase + 3'd1;
      end
    end
  end

endmodule

// ===== design/square_window_rotator.sv =====
// Square window rotator top level: APB size register, result register and assertions.
// Depends on swr_pkg, swr_matrix_mem and swr_ctrl.
//
// The block holds a MAX_SIDE x MAX_SIDE matrix of 19-bit cells in one memory with one
// write and one read port. A fill writes all n*n cells, one cell per cycle. A rotation
// of radius r walks the window in orbits of four cells, each read and written back
// through the shared memory ports. One request is worked on at a time; a new request
// is taken while the previous result waits in the output register. Cell contents are
// undefined until the first fill, and size_in_use is clamped to 1..MAX_SIDE where used.
module square_window_rotator #(
  parameter int MAX_SIDE = swr_pkg::MAX_SIDE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [swr_pkg::REQ_W-1:0]     req_type,
  input  logic [swr_pkg::COORD_W-1:0]   row,
  input  logic [swr_pkg::COORD_W-1:0]   col,
  input  logic [swr_pkg::RAD_W-1:0]     radius,
  input  logic                          counter_clockwise,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic [swr_pkg::VAL_W-1:0]     cell_value,
  output logic                          status
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int IW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [swr_pkg::SIZE_W-1:0] size_in_use;
  logic [swr_pkg::SIDE_W-1:0] side;
  logic                       cfg_write;
  logic                       res_take;
  swr_pkg::result_t           res;
  swr_pkg::mem_ctl_t          mem_ctl;
  logic [AW-1:0]              raddr, waddr;
  logic [swr_pkg::VAL_W-1:0]  wdata, rdata;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2:2] == swr_pkg::REG_SIZE_IN_USE);

  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= swr_pkg::SIZE_RESET;
    end else if (cfg_write) begin
      size_in_use <= pwdata[swr_pkg::SIZE_W-1:0];
    end
  end

  assign prdata = (paddr[2:2] == swr_pkg::REG_SIZE_IN_USE) ?
                  {{(32-swr_pkg::SIZE_W){1'b0}}, size_in_use} : 32'd0;

  always_comb begin
    if (size_in_use == '0) begin
      side = 11'd1;
    end else if ({1'b0, size_in_use} > swr_pkg::SIDE_W'(MAX_SIDE)) begin
      side = swr_pkg::SIDE_W'(MAX_SIDE);
    end else begin
      side = {1'b0, size_in_use};
    end
  end

  swr_ctrl #(
    .MAX_SIDE(MAX_SIDE),
    .IW      (IW),
    .AW      (AW)
  ) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_valid),
    .idle             (req_ready),
    .req_type         (req_type),
    .row              (row),
    .col              (col),
    .radius           (radius),
    .counter_clockwise(counter_clockwise),
    .side             (side),
    .res_take         (res_take),
    .res              (res),
    .mem_ctl          (mem_ctl),
    .raddr            (raddr),
    .waddr            (waddr),
    .wdata            (wdata),
    .rdata            (rdata)
  );

  swr_matrix_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .ctl  (mem_ctl),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign res_take = res.valid && (!rsp_valid || rsp_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      cell_value <= res.value;
      status     <= res.status;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while the sequencer stayed idle");

  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && res.valid))
    else $error("sequencer idle while holding a result");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status |-> cell_value == '0)
    else $error("rejected request returned a nonzero cell value");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !mem_ctl.wr_en)
    else $error("matrix write while no request is in progress");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for square_window_rotator: directed and random requests
// checked beat by beat against an in-bench model of the matrix store.
// Depends on swr_pkg and the square_window_rotator RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SIDE = swr_pkg::MAX_SIDE_DEF;
  localparam int CELLS = MAX_SIDE * MAX_SIDE;
  localparam logic [swr_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic [2:0] SIZE_REG_ADDR = 3'(4 * int'(swr_pkg::REG_SIZE_IN_USE));
  localparam int CHEAP_SIDE = 16;
  localparam int CHEAP_RADIUS = 7;
  localparam int NOISE_RADIUS = 16;
  localparam int PHASES = 12;
  localparam int ITEMS_PER_PHASE = 92;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [swr_pkg::REQ_W-1:0]   kind;
    logic [swr_pkg::COORD_W-1:0] row;
    logic [swr_pkg::COORD_W-1:0] col;
    logic [swr_pkg::RAD_W-1:0]   radius;
    logic                        ccw;
  } swr_req_t;

  typedef struct packed {
    logic                      status;
    logic [swr_pkg::VAL_W-1:0] value;
  } cell_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic req_valid = 1'b0;
  logic req_ready;
  logic [swr_pkg::REQ_W-1:0] req_type = '0;
  logic [swr_pkg::COORD_W-1:0] row = '0;
  logic [swr_pkg::COORD_W-1:0] col = '0;
  logic [swr_pkg::RAD_W-1:0] radius = '0;
  logic counter_clockwise = 1'b0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  logic [swr_pkg::VAL_W-1:0] cell_value;
  logic status;

  bit [swr_pkg::VAL_W-1:0] model_cells [CELLS];
  bit [swr_pkg::VAL_W-1:0] window_snapshot [CELLS];
  int side_n = MAX_SIDE;

  swr_req_t pending_reqs [$];
  cell_result_t expected_cells [$];
  swr_req_t on_bus;
  int queued_total = 0;
  int accepted_total = 0;
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  square_window_rotator u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req_valid(req_valid), .req_ready(req_ready),
    .req_type(req_type), .row(row), .col(col), .radius(radius),
    .counter_clockwise(counter_clockwise),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .cell_value(cell_value), .status(status)
  );

  always #6 clk = ~clk;

  function automatic int cell_index(int i, int j);
    return (i - 1) * MAX_SIDE + (j - 1);
  endfunction

  function automatic bit window_fits(int a, int b, int r, int n);
    return (a - r >= 1) && (a + r <= n) && (b - r >= 1) && (b + r <= n);
  endfunction

  function automatic cell_result_t apply_request(swr_req_t rq);
    cell_result_t res;
    int a, b, r, side, di, dj, count;
    bit [swr_pkg::VAL_W-1:0] v;
    res = '0;
    a = int'(rq.row);
    b = int'(rq.col);
    r = int'(rq.radius);
    side = 2 * r + 1;
    case (rq.kind)
      swr_pkg::REQ_ROTATE: begin
        if (!window_fits(a, b, r, side_n)) begin
          res.status = 1'b1;
        end else begin
          for (di = -r; di <= r; di++)
            for (dj = -r; dj <= r; dj++)
              window_snapshot[(di + r) * side + (dj + r)] =
                model_cells[cell_index(a + di, b + dj)];
          for (di = -r; di <= r; di++)
            for (dj = -r; dj <= r; dj++) begin
              v = window_snapshot[(di + r) * side + (dj + r)];
              if (rq.ccw) model_cells[cell_index(a - dj, b + di)] = v;
              else model_cells[cell_index(a + dj, b - di)] = v;
            end
        end
      end
      swr_pkg::REQ_READ: begin
        if (a >= 1 && a <= side_n && b >= 1 && b <= side_n)
          res.value = model_cells[cell_index(a, b)];
        else res.status = 1'b1;
      end
      swr_pkg::REQ_FILL: begin
        count = 0;
        for (int i = 1; i <= side_n; i++)
          for (int j = 1; j <= side_n; j++) begin
            count++;
            model_cells[cell_index(i, j)] = count[swr_pkg::VAL_W-1:0];
          end
      end
      default: res.status = 1'b1;
    endcase
    return res;
  endfunction

  function automatic swr_req_t mk_req(logic [swr_pkg::REQ_W-1:0] kind, int r_row,
                                      int r_col, int rad, bit ccw);
    swr_req_t rq;
    rq.kind = kind;
    rq.row = r_row[swr_pkg::COORD_W-1:0];
    rq.col = r_col[swr_pkg::COORD_W-1:0];
    rq.radius = rad[swr_pkg::RAD_W-1:0];
    rq.ccw = ccw;
    return rq;
  endfunction

  function automatic swr_req_t random_request(int n);
    swr_req_t rq;
    int pick, r;
    pick = int'($urandom_range(99));
    rq = mk_req(swr_pkg::REQ_READ, int'($urandom), int'($urandom), int'($urandom),
                1'($urandom));
    if (pick < 8) begin
      rq.kind = (n <= CHEAP_SIDE) ? swr_pkg::REQ_FILL : swr_pkg::REQ_READ;
      rq.row = swr_pkg::COORD_W'($urandom_range(1, n));
      rq.col = swr_pkg::COORD_W'($urandom_range(1, n));
    end else if (pick < 45) begin
      r = int'($urandom_range(0, ((n - 1) / 2 < CHEAP_RADIUS) ? (n - 1) / 2 : CHEAP_RADIUS));
      rq.kind = swr_pkg::REQ_ROTATE;
      rq.radius = swr_pkg::RAD_W'(r);
      rq.row = swr_pkg::COORD_W'($urandom_range(r + 1, n - r));
      rq.col = swr_pkg::COORD_W'($urandom_range(r + 1, n - r));
    end else if (pick < 85) begin
      rq.row = swr_pkg::COORD_W'($urandom_range(1, n));
      rq.col = swr_pkg::COORD_W'($urandom_range(1, n));
    end else begin
      rq.kind = swr_pkg::REQ_W'($urandom_range(3));
      if (rq.kind == swr_pkg::REQ_FILL && n > CHEAP_SIDE) rq.kind = swr_pkg::REQ_READ;
      if (rq.kind == swr_pkg::REQ_ROTATE && int'(rq.radius) >= NOISE_RADIUS &&
          window_fits(int'(rq.row), int'(rq.col), int'(rq.radius), n))
        rq.radius = swr_pkg::RAD_W'(int'(rq.radius) % NOISE_RADIUS);
    end
    return rq;
  endfunction

  task automatic push_request(swr_req_t rq);
    pending_reqs.push_back(rq);
    queued_total++;
  endtask

  task automatic wait_for_drain();
    do @(posedge clk);
    while (accepted_total != queued_total || expected_cells.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_side(int unsigned v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SIZE_REG_ADDR;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    side_n = (v[swr_pkg::SIZE_W-1:0] == '0) ? 1 :
             (int'(v[swr_pkg::SIZE_W-1:0]) > MAX_SIDE) ? MAX_SIDE :
             int'(v[swr_pkg::SIZE_W-1:0]);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      1: begin send_idle_pct = 54; recv_stall_pct = 0; end
      2: begin send_idle_pct = 0; recv_stall_pct = 54; end
      3: begin send_idle_pct = 7; recv_stall_pct = 7; end
      default: begin send_idle_pct = 0; recv_stall_pct = 0; end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        expected_cells.push_back(apply_request(on_bus));
        accepted_total++;
      end
      if (!req_valid || req_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = pending_reqs.pop_front();
          req_type <= on_bus.kind;
          row <= on_bus.row;
          col <= on_bus.col;
          radius <= on_bus.radius;
          counter_clockwise <= on_bus.ccw;
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    cell_result_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_cells.size() == 0) begin
          $error("result beat with no request outstanding");
          mismatches++;
        end else begin
          want = expected_cells.pop_front();
          if (cell_value !== want.value) begin
            $error("cell_value: expected %0d, got %0d", want.value, cell_value);
            mismatches++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            mismatches++;
          end
        end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    int unsigned code;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    write_side(MAX_SIDE);
    set_idling(0);

    // Rejected requests before the first fill never touch a cell; a fill, then reads and rotations follow.
    push_request(mk_req(swr_pkg::REQ_READ, 0, 0, 0, 0));
    push_request(mk_req(swr_pkg::REQ_ROTATE, 1, 1, 255, 0));
    push_request(mk_req(REQ_UNUSED, 1023, 1023, 255, 1));
    push_request(mk_req(swr_pkg::REQ_READ, 1023, 1023, 255, 1));
    push_request(mk_req(swr_pkg::REQ_FILL, 1023, 0, 255, 1));
    push_request(mk_req(swr_pkg::REQ_READ, 1, 1, 0, 0));
    push_request(mk_req(swr_pkg::REQ_READ, 512, 512, 0, 0));
    push_request(mk_req(swr_pkg::REQ_READ, 1, 512, 0, 0));
    push_request(mk_req(swr_pkg::REQ_ROTATE, 256, 256, 255, 0));
    push_request(mk_req(swr_pkg::REQ_READ, 1, 1, 0, 0));
    push_request(mk_req(swr_pkg::REQ_READ, 1, 511, 0, 0));
    push_request(mk_req(swr_pkg::REQ_READ, 512, 512, 0, 0));
    push_request(mk_req(swr_pkg::REQ_READ, 512, 1, 0, 0));
    push_request(mk_req(swr_pkg::REQ_ROTATE, 256, 256, 0, 1));
    push_request(mk_req(swr_pkg::REQ_ROTATE, 2, 2, 1, 1));
    push_request(mk_req(swr_pkg::REQ_READ, 1, 1, 0, 0));
    push_request(mk_req(swr_pkg::REQ_READ, 1, 3, 0, 0));
    push_request(mk_req(swr_pkg::REQ_ROTATE, 512, 512, 0, 0));
    push_request(mk_req(swr_pkg::REQ_ROTATE, 511, 511, 1, 0));
    push_request(mk_req(swr_pkg::REQ_READ, 512, 512, 0, 0));
    push_request(mk_req(swr_pkg::REQ_ROTATE, 512, 256, 1, 1));
    push_request(mk_req(swr_pkg::REQ_READ, 513, 1, 0, 0));
    push_request(mk_req(swr_pkg::REQ_READ, 1, 513, 0, 0));
    wait_for_drain();

    for (int p = 0; p < PHASES; p++) begin
      code = (p == 1) ? 1 : (p == 4) ? 0 : (p == 7) ? 1023 : $urandom_range(2, CHEAP_SIDE);
      write_side(code);
      set_idling(p % 4);
      if (side_n <= CHEAP_SIDE)
        push_request(mk_req(swr_pkg::REQ_FILL, int'($urandom), int'($urandom),
                            int'($urandom), 1'($urandom)));
      for (int k = 0; k < ITEMS_PER_PHASE; k++)
        push_request(random_request(side_n));
      wait_for_drain();
    end

    repeat (20) @(posedge clk);
    if (expected_cells.size() != 0) begin
      $error("%0d expected results never arrived", expected_cells.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #250_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
